>>> hw/rtl/rss_pkg.sv
// Shared constants, register codes and types of the rotated sprite sampler.
`timescale 1ns / 1ps

package rss_pkg;

    localparam int SPRITE_COLS = 64;
    localparam int SPRITE_ROWS = 16;
    localparam int SCREEN_COLS = 128;
    localparam int SCREEN_ROWS = 32;
    localparam int FRAC_BITS   = 16;

    localparam int STORE_DEPTH = SPRITE_COLS * SPRITE_ROWS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int COL_W       = (SPRITE_COLS > 1) ? $clog2(SPRITE_COLS) : 1;
    localparam int ROW_W       = (SPRITE_ROWS > 1) ? $clog2(SPRITE_ROWS) : 1;

    localparam int COEF_W     = 18;
    localparam int CCOL_W     = 23;
    localparam int CROW_W     = 21;
    localparam int SW_W       = 7;
    localparam int SH_W       = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam int SCOL_W = 6;
    localparam int SROW_W = 4;
    localparam int CHAR_W = 8;
    localparam int SX_W   = 7;
    localparam int SY_W   = 5;

    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'd32;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Load value of the settle counter, which counts down after a register write until the derived offsets are valid.
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_COEF      = 3'd0,
        REG_SIN_COEF      = 3'd1,
        REG_CENTER_COL    = 3'd2,
        REG_CENTER_ROW    = 3'd3,
        REG_SPRITE_WIDTH  = 3'd4,
        REG_SPRITE_HEIGHT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] cos_coef;
        logic signed [COEF_W-1:0] sin_coef;
        logic [31:0]              off_col;
        logic [31:0]              off_row;
        logic [SW_W-1:0]          width_eff;
        logic [SH_W-1:0]          height_eff;
    } rss_geom_t;

    typedef struct packed {
        logic              is_write;
        logic              is_sample;
        logic              in_sprite;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] wdata;
    } rss_access_t;

endpackage

>>> hw/rtl/rss_cfg.sv
// Configuration registers and the derived rotation offsets.
`timescale 1ns / 1ps

module rss_cfg
    import rss_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output rss_geom_t             geom,
    output logic                  cfg_busy
);

    logic signed [COEF_W-1:0] cos_reg;
    logic signed [COEF_W-1:0] sin_reg;
    logic [CCOL_W-1:0]        ccol_reg;
    logic [CROW_W-1:0]        crow_reg;
    logic [SW_W-1:0]          width_reg;
    logic [SH_W-1:0]          height_reg;
    logic [1:0]               settle_reg;

    localparam int PCC_W = CCOL_W + 1 + COEF_W;
    localparam int PCR_W = CROW_W + 1 + COEF_W;

    logic signed [PCC_W-1:0] p_cc_cos_next, p_cc_cos_reg, p_cc_sin_next, p_cc_sin_reg;
    logic signed [PCR_W-1:0] p_cr_cos_next, p_cr_cos_reg, p_cr_sin_next, p_cr_sin_reg;
    logic signed [PCC_W-1:0] sh_cc_cos, sh_cc_sin;
    logic signed [PCR_W-1:0] sh_cr_cos, sh_cr_sin;
    logic [31:0]             off_col_next, off_col_reg, off_row_next, off_row_reg;
    logic [SW_W-1:0]         width_eff_next, width_eff_reg;
    logic [SH_W-1:0]         height_eff_next, height_eff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg    <= 18'sd65536;
            sin_reg    <= '0;
            ccol_reg   <= '0;
            crow_reg   <= '0;
            width_reg  <= 7'd64;
            height_reg <= 5'd16;
            settle_reg <= SETTLE_CYCLES;
        end else begin
            if (cfg_we) begin
                settle_reg <= SETTLE_CYCLES;
                unique case (cfg_reg_t'(cfg_index))
                    REG_COS_COEF:      cos_reg    <= signed'(cfg_wdata[COEF_W-1:0]);
                    REG_SIN_COEF:      sin_reg    <= signed'(cfg_wdata[COEF_W-1:0]);
                    REG_CENTER_COL:    ccol_reg   <= cfg_wdata[CCOL_W-1:0];
                    REG_CENTER_ROW:    crow_reg   <= cfg_wdata[CROW_W-1:0];
                    REG_SPRITE_WIDTH:  width_reg  <= cfg_wdata[SW_W-1:0];
                    REG_SPRITE_HEIGHT: height_reg <= cfg_wdata[SH_W-1:0];
                    default: ;
                endcase
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    always_comb begin
        p_cc_cos_next = $signed({1'b0, ccol_reg}) * cos_reg;
        p_cc_sin_next = $signed({1'b0, ccol_reg}) * sin_reg;
        p_cr_cos_next = $signed({1'b0, crow_reg}) * cos_reg;
        p_cr_sin_next = $signed({1'b0, crow_reg}) * sin_reg;
        width_eff_next  = (32'(width_reg) > SPRITE_COLS) ? SW_W'(SPRITE_COLS) : width_reg;
        height_eff_next = (32'(height_reg) > SPRITE_ROWS) ? SH_W'(SPRITE_ROWS) : height_reg;
    end

    always_ff @(posedge aclk) begin
        p_cc_cos_reg   <= p_cc_cos_next;
        p_cc_sin_reg   <= p_cc_sin_next;
        p_cr_cos_reg   <= p_cr_cos_next;
        p_cr_sin_reg   <= p_cr_sin_next;
        width_eff_reg  <= width_eff_next;
        height_eff_reg <= height_eff_next;
        off_col_reg    <= off_col_next;
        off_row_reg    <= off_row_next;
    end

    // Floor of each product over 2^16, cut to 32 bits.
    always_comb begin
        sh_cc_cos = p_cc_cos_reg >>> FRAC_BITS;
        sh_cc_sin = p_cc_sin_reg >>> FRAC_BITS;
        sh_cr_cos = p_cr_cos_reg >>> FRAC_BITS;
        sh_cr_sin = p_cr_sin_reg >>> FRAC_BITS;
        off_col_next = 32'(ccol_reg) - sh_cc_cos[31:0] + sh_cr_sin[31:0];
        off_row_next = 32'(crow_reg) - sh_cr_cos[31:0] - sh_cc_sin[31:0];
    end

    always_comb begin
        geom.cos_coef   = cos_reg;
        geom.sin_coef   = sin_reg;
        geom.off_col    = off_col_reg;
        geom.off_row    = off_row_reg;
        geom.width_eff  = width_eff_reg;
        geom.height_eff = height_eff_reg;
        cfg_busy        = cfg_we || (settle_reg != 2'd0);
    end

endmodule

>>> hw/rtl/rss_map.sv
// Two-stage coordinate mapping from a screen pixel to a sprite store access.
`timescale 1ns / 1ps

module rss_map
    import rss_pkg::*;
(
    input  logic              aclk,
    input  logic              st1_load,
    input  logic              st2_load,
    input  logic              in_cmd,
    input  logic [SCOL_W-1:0] in_col,
    input  logic [SROW_W-1:0] in_row,
    input  logic [CHAR_W-1:0] in_char,
    input  logic [SX_W-1:0]   in_x,
    input  logic [SY_W-1:0]   in_y,
    input  rss_geom_t         geom,
    output rss_access_t       acc
);

    localparam int PX_W = SX_W + 1 + COEF_W;
    localparam int PY_W = SY_W + 1 + COEF_W;

    // Stage 1: the item as taken.
    logic              cmd1_reg;
    logic [SCOL_W-1:0] col1_reg;
    logic [SROW_W-1:0] row1_reg;
    logic [CHAR_W-1:0] char1_reg;
    logic [SX_W-1:0]   x1_reg;
    logic [SY_W-1:0]   y1_reg;

    // Stage 2: products and decoded write.
    logic                  wr2_reg, wr2_next;
    logic                  smp2_reg, smp2_next;
    logic                  onscr2_reg, onscr2_next;
    logic [ADDR_W-1:0]     waddr2_reg, waddr2_next;
    logic [CHAR_W-1:0]     char2_reg;
    logic signed [PX_W-1:0] pxc_reg, pxc_next, pxs_reg, pxs_next;
    logic signed [PY_W-1:0] pyc_reg, pyc_next, pys_reg, pys_next;

    logic [31:0]       sum_c, sum_r;
    logic              in_c, in_r;
    logic [COL_W-1:0]  col_idx;
    logic [ROW_W-1:0]  row_idx;

    always_ff @(posedge aclk) begin
        if (st1_load) begin
            cmd1_reg  <= in_cmd;
            col1_reg  <= in_col;
            row1_reg  <= in_row;
            char1_reg <= in_char;
            x1_reg    <= in_x;
            y1_reg    <= in_y;
        end
    end

    always_comb begin
        wr2_next    = (cmd1_reg == CMD_WRITE) && (32'(col1_reg) < SPRITE_COLS)
                      && (32'(row1_reg) < SPRITE_ROWS);
        smp2_next   = (cmd1_reg == CMD_SAMPLE);
        onscr2_next = (32'(x1_reg) < SCREEN_COLS) && (32'(y1_reg) < SCREEN_ROWS);
        waddr2_next = ADDR_W'(32'(row1_reg) * SPRITE_COLS + 32'(col1_reg));
        pxc_next    = $signed({1'b0, x1_reg}) * geom.cos_coef;
        pxs_next    = $signed({1'b0, x1_reg}) * geom.sin_coef;
        pyc_next    = $signed({1'b0, y1_reg}) * geom.cos_coef;
        pys_next    = $signed({1'b0, y1_reg}) * geom.sin_coef;
    end

    always_ff @(posedge aclk) begin
        if (st2_load) begin
            wr2_reg    <= wr2_next;
            smp2_reg   <= smp2_next;
            onscr2_reg <= onscr2_next;
            waddr2_reg <= waddr2_next;
            char2_reg  <= char1_reg;
            pxc_reg    <= pxc_next;
            pxs_reg    <= pxs_next;
            pyc_reg    <= pyc_next;
            pys_reg    <= pys_next;
        end
    end

    // Wrapping 32-bit sums; a negative source has its sign bit set and falls outside.
    always_comb begin
        sum_c = geom.off_col + {{(32-PX_W){pxc_reg[PX_W-1]}}, pxc_reg}
                - {{(32-PY_W){pys_reg[PY_W-1]}}, pys_reg};
        sum_r = geom.off_row + {{(32-PX_W){pxs_reg[PX_W-1]}}, pxs_reg}
                + {{(32-PY_W){pyc_reg[PY_W-1]}}, pyc_reg};
        in_c  = !sum_c[31] && (sum_c[31:FRAC_BITS] < 16'(geom.width_eff));
        in_r  = !sum_r[31] && (sum_r[31:FRAC_BITS] < 16'(geom.height_eff));
        col_idx = sum_c[FRAC_BITS +: COL_W];
        row_idx = sum_r[FRAC_BITS +: ROW_W];

        acc.is_write  = wr2_reg;
        acc.is_sample = smp2_reg;
        acc.in_sprite = onscr2_reg && in_c && in_r;
        acc.wdata     = char2_reg;
        acc.addr      = wr2_reg ? waddr2_reg
                                : ADDR_W'(32'(row_idx) * SPRITE_COLS + 32'(col_idx));
    end

endmodule

>>> hw/rtl/rss_store.sv
// Sprite character store with one write or one registered read per enabled cycle.
`timescale 1ns / 1ps

module rss_store
    import rss_pkg::*;
(
    input  logic              aclk,
    input  logic              acc_en,
    input  rss_access_t       acc,
    output logic [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] mem [STORE_DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (acc_en && acc.is_write) begin
            mem[acc.addr] <= acc.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_en && acc.is_sample) begin
            rdata_reg <= mem[acc.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/rotated_sprite_sampler.sv
// Top level of the rotated sprite sampler: stream handshake, pipeline control, result register.
`timescale 1ns / 1ps

// The block takes one item per clock while s_tready is high and returns a sampled
// pixel through an input stage, a stage that holds the coefficient products, and
// the registered read of the sprite store, which is the result register. Write items
// (tuser 0) store one character and give no result; sample items (tuser 1) give one
// result each, in order. The rate is set by the single store port, which serves one
// write or one read per cycle. After reset and after every configuration write the
// rotation offsets are rebuilt from the registers over two registered steps, so
// s_tready stays low during the write and until they are rebuilt. The store has no
// reset; sample only cells that have been written.

module rotated_sprite_sampler
    import rss_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [5:0] sprite_col, [9:6] sprite_row, [17:10] char_value,
    // [24:18] screen_x, [29:25] screen_y, [31:30] zero
    input  logic [31:0]           s_tdata,
    // [0] cmd
    input  logic [0:0]            s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] glyph
    output logic [7:0]            m_tdata,
    // [0] inside_res
    output logic [0:0]            m_tuser
);

    rss_geom_t         geom;
    rss_access_t       acc;
    logic              cfg_busy;
    logic [CHAR_W-1:0] rdata;

    logic st1_valid_reg, st1_valid_next;
    logic st2_valid_reg, st2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic inside_reg;

    logic out_free, st2_free, st1_free;
    logic st1_move, st2_move, in_take;

    // Registers and the offsets that follow from them.
    rss_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .geom      (geom),
        .cfg_busy  (cfg_busy)
    );

    // Map the pixel back into the sprite.
    rss_map u_map (
        .aclk     (aclk),
        .st1_load (in_take),
        .st2_load (st1_move),
        .in_cmd   (s_tuser[0]),
        .in_col   (s_tdata[5:0]),
        .in_row   (s_tdata[9:6]),
        .in_char  (s_tdata[17:10]),
        .in_x     (s_tdata[24:18]),
        .in_y     (s_tdata[29:25]),
        .geom     (geom),
        .acc      (acc)
    );

    // Store writes and reads happen at the same step, so items keep their order.
    rss_store u_store (
        .aclk   (aclk),
        .acc_en (st2_move),
        .acc    (acc),
        .rdata  (rdata)
    );

    // A stage may advance when the one after it is empty or moving on.
    always_comb begin
        out_free = !out_valid_reg || m_tready;
        st2_move = st2_valid_reg && out_free;
        st2_free = !st2_valid_reg || out_free;
        st1_move = st1_valid_reg && st2_free;
        st1_free = !st1_valid_reg || st2_free;
        s_tready = st1_free && !cfg_busy;
        in_take  = s_tvalid && s_tready;
    end

    always_comb begin
        st1_valid_next = in_take || (st1_valid_reg && !st2_free);
        st2_valid_next = st1_move || (st2_valid_reg && !out_free);
        // Only a sample leaves a result; a write is dropped once it reaches the store.
        if (st2_move && acc.is_sample) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the inside flag beside the store's read register.
    always_ff @(posedge aclk) begin
        if (st2_move && acc.is_sample) begin
            inside_reg <= acc.in_sprite;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = inside_reg ? rdata : BLANK_CHAR;
    assign m_tuser[0] = inside_reg;

    // No item may enter while the offsets are still being rebuilt.
    a_no_take_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |-> !cfg_busy)
        else $error("item taken while offsets settle");

    // A register write keeps the input closed in the next cycle too.
    a_cfg_closes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("input open right after a register write");

    // A write item reaching the store never raises a result.
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (st2_move && !acc.is_sample && m_tready) |=> !m_tvalid)
        else $error("write item produced a result");

    // A stalled first stage keeps its item.
    a_st1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && !st2_free) |=> st1_valid_reg)
        else $error("first stage lost an item under stall");

endmodule
